// ----- design/rqpf_pkg.sv -----
// Package for the ready queue: depth, widths, status codes and the
// control bundle that the sequencer sends along the row of queue cells.
// No dependencies.
package rqpf_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ID_W        = 8;
  localparam int PRIO_W      = 8;
  localparam int STATUS_W    = 2;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 24;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_REMOVE = 1'b1
  } req_t;

  // Operation applied by every cell in the same cycle.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_SEARCH,
    CELL_INSERT,
    CELL_SHIFT_OUT
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic [ID_W-1:0]    new_id;
    logic [PRIO_W-1:0]  new_prio;
    logic               mode;
  } cell_ctrl_t;

endpackage

// ----- design/ready_queue_priority_or_fifo.sv -----
// Top level of the ready queue: a row of queue cells and their sequencer.
// Depends on rqpf_pkg, rqpf_cell and rqpf_ctrl.
//
// Channel   Direction  Signals                         Content
// in_       slave      tvalid tready tdata tuser       request: kind, id, priority
// out_      master     tvalid tready tdata             result: status, id, priority
// cfg_      write      wr_en wr_data                   priority_mode register
//
// A remove or a rejected request leaves the sequencer idle; its result is
// registered at acceptance. An accepted insert runs in steps: at acceptance
// the search marks are cleared, then the insert mark ripples one cell per
// cycle down the row, and a last step shifts the tail and writes the new
// entry. Reset (rst_n low, synchronous) empties the queue and selects plain
// tail mode; entry contents are not cleared. A new request is taken once the
// sequencer is idle and the result register is empty or being drained, so a
// stalled result channel holds off further requests.
module ready_queue_priority_or_fifo (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tdata: [7:0] process_id, [15:8] priority_req
  input  logic [rqpf_pkg::IN_DATA_W-1:0]    in_tdata,
  // tuser: [0] req_type (0 insert, 1 remove)
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // tdata: [1:0] status, [9:2] out_process_id, [17:10] out_priority,
  // [23:18] zero
  output logic [rqpf_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                              cfg_wr_en,
  input  logic                              cfg_wr_data
);
  import rqpf_pkg::*;

  cell_ctrl_t        ctrl;
  logic [CNT_W-1:0]  count;
  status_t           res_status;
  logic [ID_W-1:0]   res_id;
  logic [PRIO_W-1:0] res_prio;

  // Per-cell views of the row. Position 0 is the head of the queue.
  logic [QUEUE_DEPTH-1:0] occupied;
  logic [QUEUE_DEPTH-1:0] at_tail;
  logic [QUEUE_DEPTH-1:0] mark;
  logic [ID_W-1:0]        cell_id   [QUEUE_DEPTH];
  logic [PRIO_W-1:0]      cell_prio [QUEUE_DEPTH];

  rqpf_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_req      (in_tuser),
    .in_id       (in_tdata[7:0]),
    .in_prio     (in_tdata[15:8]),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_status  (res_status),
    .out_id      (res_id),
    .out_prio    (res_prio),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .head_id     (cell_id[0]),
    .head_prio   (cell_prio[0]),
    .ctrl        (ctrl),
    .count       (count)
  );

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    // Occupancy is derived from the count, so cells carry no valid bits.
    assign occupied[i] = (CNT_W'(i) < count);
    assign at_tail[i]  = (CNT_W'(i) == count);

    if (i == 0) begin : g_head
      rqpf_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .occupied   (occupied[i]),
        .at_tail    (at_tail[i]),
        .left_mark  (1'b0),
        .left_id    (ctrl.new_id),
        .left_prio  (ctrl.new_prio),
        .right_id   (cell_id[(i + 1) % QUEUE_DEPTH]),
        .right_prio (cell_prio[(i + 1) % QUEUE_DEPTH]),
        .mark       (mark[i]),
        .id         (cell_id[i]),
        .prio       (cell_prio[i])
      );
    end else if (i == QUEUE_DEPTH - 1) begin : g_last
      // The last cell has no right neighbor; on a remove it keeps its entry,
      // which then lies beyond the count and is never read.
      rqpf_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .occupied   (occupied[i]),
        .at_tail    (at_tail[i]),
        .left_mark  (mark[i - 1]),
        .left_id    (cell_id[i - 1]),
        .left_prio  (cell_prio[i - 1]),
        .right_id   (cell_id[i]),
        .right_prio (cell_prio[i]),
        .mark       (mark[i]),
        .id         (cell_id[i]),
        .prio       (cell_prio[i])
      );
    end else begin : g_mid
      rqpf_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .occupied   (occupied[i]),
        .at_tail    (at_tail[i]),
        .left_mark  (mark[i - 1]),
        .left_id    (cell_id[i - 1]),
        .left_prio  (cell_prio[i - 1]),
        .right_id   (cell_id[i + 1]),
        .right_prio (cell_prio[i + 1]),
        .mark       (mark[i]),
        .id         (cell_id[i]),
        .prio       (cell_prio[i])
      );
    end
  end

  assign out_tdata = {(OUT_DATA_W - STATUS_W - ID_W - PRIO_W)'(0),
                      res_prio, res_id, res_status};

endmodule

// ----- design/rqpf_cell.sv -----
// One queue cell: holds one entry and a search mark, and trades entries
// with its neighbors. Depends on rqpf_pkg.
module rqpf_cell (
  input  logic                      clk,
  input  rqpf_pkg::cell_ctrl_t      ctrl,
  input  logic                      occupied,
  input  logic                      at_tail,
  input  logic                      left_mark,
  input  logic [rqpf_pkg::ID_W-1:0]   left_id,
  input  logic [rqpf_pkg::PRIO_W-1:0] left_prio,
  input  logic [rqpf_pkg::ID_W-1:0]   right_id,
  input  logic [rqpf_pkg::PRIO_W-1:0] right_prio,
  output logic                      mark,
  output logic [rqpf_pkg::ID_W-1:0]   id,
  output logic [rqpf_pkg::PRIO_W-1:0] prio
);
  import rqpf_pkg::*;

  logic [ID_W-1:0]   id_r,   id_nxt;
  logic [PRIO_W-1:0] prio_r, prio_nxt;
  logic              mark_r, mark_nxt;
  logic              greater;

  // This entry is one the new request must go in front of.
  assign greater = ctrl.mode & occupied & (ctrl.new_prio < prio_r);

  always_comb begin
    id_nxt   = id_r;
    prio_nxt = prio_r;
    mark_nxt = mark_r;
    case (ctrl.op)
      CELL_CLEAR:  mark_nxt = 1'b0;
      // The mark ripples one cell per cycle; it becomes a prefix OR.
      CELL_SEARCH: mark_nxt = left_mark | greater;
      CELL_INSERT: begin
        if (occupied || at_tail) begin
          if (mark_r && left_mark) begin
            id_nxt   = left_id;
            prio_nxt = left_prio;
          end else if (mark_r || at_tail) begin
            id_nxt   = ctrl.new_id;
            prio_nxt = ctrl.new_prio;
          end
        end
      end
      CELL_SHIFT_OUT: begin
        id_nxt   = right_id;
        prio_nxt = right_prio;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    id_r   <= id_nxt;
    prio_r <= prio_nxt;
    mark_r <= mark_nxt;
  end

  assign mark = mark_r;
  assign id   = id_r;
  assign prio = prio_r;

endmodule

// ----- design/rqpf_ctrl.sv -----
// Sequencer for the ready queue: request handshake, mode register, entry
// count, search step counter and the result register. Depends on rqpf_pkg.
module rqpf_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic                        in_req,
  input  logic [rqpf_pkg::ID_W-1:0]   in_id,
  input  logic [rqpf_pkg::PRIO_W-1:0] in_prio,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output rqpf_pkg::status_t           out_status,
  output logic [rqpf_pkg::ID_W-1:0]   out_id,
  output logic [rqpf_pkg::PRIO_W-1:0] out_prio,
  input  logic                        cfg_wr_en,
  input  logic                        cfg_wr_data,
  input  logic [rqpf_pkg::ID_W-1:0]   head_id,
  input  logic [rqpf_pkg::PRIO_W-1:0] head_prio,
  output rqpf_pkg::cell_ctrl_t        ctrl,
  output logic [rqpf_pkg::CNT_W-1:0]  count
);
  import rqpf_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_APPLY
  } state_t;

  state_t            state_r;
  logic              mode_r;
  logic [CNT_W-1:0]  count_r;
  logic [IDX_W-1:0]  step_r;
  logic [ID_W-1:0]   new_id_r;
  logic [PRIO_W-1:0] new_prio_r;
  logic              out_valid_r;
  status_t           out_status_r;
  logic [ID_W-1:0]   out_id_r;
  logic [PRIO_W-1:0] out_prio_r;
  logic              accept;
  logic              full;
  logic              empty;

  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;
  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty     = (count_r == '0);

  always_comb begin
    ctrl.op       = CELL_HOLD;
    ctrl.new_id   = new_id_r;
    ctrl.new_prio = new_prio_r;
    ctrl.mode     = mode_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_req == REQ_REMOVE) begin
            if (!empty) ctrl.op = CELL_SHIFT_OUT;
          end else if (!full) begin
            ctrl.op = CELL_CLEAR;
          end
        end
      end
      ST_SEARCH: ctrl.op = CELL_SEARCH;
      ST_APPLY:  ctrl.op = CELL_INSERT;
      default:   ctrl.op = CELL_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= 1'b0;
      count_r     <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) mode_r <= cfg_wr_data;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if ((in_req == REQ_REMOVE) && !empty) begin
              out_status_r <= STATUS_DONE;
              out_id_r     <= head_id;
              out_prio_r   <= head_prio;
              count_r      <= count_r - CNT_W'(1);
            end else begin
              out_id_r   <= '0;
              out_prio_r <= '0;
              if (in_req == REQ_REMOVE) begin
                out_status_r <= STATUS_EMPTY;
              end else if (full) begin
                out_status_r <= STATUS_FULL;
              end else begin
                out_status_r <= STATUS_DONE;
                new_id_r     <= in_id;
                new_prio_r   <= in_prio;
                step_r       <= '0;
                state_r      <= ST_SEARCH;
              end
            end
          end
        end
        ST_SEARCH: begin
          step_r <= step_r + IDX_W'(1);
          if (step_r == IDX_W'(QUEUE_DEPTH - 1)) state_r <= ST_APPLY;
        end
        ST_APPLY: begin
          count_r <= count_r + CNT_W'(1);
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_status = out_status_r;
  assign out_id     = out_id_r;
  assign out_prio   = out_prio_r;
  assign count      = count_r;

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the scheduler ready queue (ready_queue_priority_or_fifo).
// It holds its own model of the bounded queue in both plain and priority mode and
// checks every result in order. Depends on rqpf_pkg and the design top level.
`timescale 1ns / 1ps

module tb_top;
  import rqpf_pkg::*;

  localparam int          CLK_HALF    = 2;
  localparam int          RESET_LEN   = 10;
  localparam int          DRAIN_WAIT  = QUEUE_DEPTH + 4;
  localparam int          LONG_HOLD   = 300;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  typedef struct packed {
    req_t              kind;
    logic [ID_W-1:0]   proc_id;
    logic [PRIO_W-1:0] prio;
  } sched_request_t;

  typedef struct packed {
    status_t           status;
    logic [ID_W-1:0]   proc_id;
    logic [PRIO_W-1:0] prio;
  } queue_result_t;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata    = '0;
  logic                  in_tuser    = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_wr_en   = 1'b0;
  logic                  cfg_wr_data = 1'b0;

  ready_queue_priority_or_fifo u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #CLK_HALF clk = ~clk;

  // Model of the ready queue: position 0 is the head.
  logic [ID_W-1:0]   model_ids   [QUEUE_DEPTH];
  logic [PRIO_W-1:0] model_prios [QUEUE_DEPTH];
  int                model_count  = 0;
  bit                model_sorted = 1'b0;

  sched_request_t pending_requests [$];
  queue_result_t  expected_results [$];

  int          mismatch_count  = 0;
  int unsigned cycle_count     = 0;
  bit          in_taken        = 1'b0;
  int          gap_left        = 0;
  int          hold_left       = 0;
  bit          sender_gaps     = 1'b1;
  bit          receiver_stalls = 1'b1;
  bit          long_hold_req   = 1'b0;

  // Applies one request to the model and returns the result the queue must give.
  function automatic queue_result_t predict_queue_result(sched_request_t req);
    queue_result_t res;
    int pos;
    res.status  = STATUS_DONE;
    res.proc_id = '0;
    res.prio    = '0;
    if (req.kind == REQ_INSERT) begin
      if (model_count >= QUEUE_DEPTH) begin
        res.status = STATUS_FULL;
      end else begin
        pos = model_count;
        // Place before the first strictly greater priority, so ties keep arrival order.
        if (model_sorted) begin
          for (int k = 0; k < model_count; k++) begin
            if (pos == model_count && req.prio < model_prios[k]) pos = k;
          end
        end
        for (int k = model_count; k > pos; k--) begin
          model_ids[k]   = model_ids[k-1];
          model_prios[k] = model_prios[k-1];
        end
        model_ids[pos]   = req.proc_id;
        model_prios[pos] = req.prio;
        model_count++;
      end
    end else begin
      if (model_count == 0) begin
        res.status = STATUS_EMPTY;
      end else begin
        res.proc_id = model_ids[0];
        res.prio    = model_prios[0];
        for (int k = 1; k < model_count; k++) begin
          model_ids[k-1]   = model_ids[k];
          model_prios[k-1] = model_prios[k];
        end
        model_count--;
      end
    end
    return res;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 96) return $urandom_range(4, 10);
    else return $urandom_range(20, 40);
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Request driver: presents the next pending request at the falling edge and holds it
  // until it is accepted, with a random gap after each accepted request.
  always @(negedge clk) begin
    sched_request_t req;
    if (!in_tvalid || in_taken) begin
      if (in_taken) begin
        in_taken = 1'b0;
        gap_left = sender_gaps ? pick_gap() : 0;
      end
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        req = pending_requests.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {req.prio, req.proc_id};
        in_tuser  <= req.kind;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, plus one long hold-off on request of the sequence.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left     = LONG_HOLD - 1;
      out_tready <= 1'b0;
    end else if (receiver_stalls && $urandom_range(0, 99) < 25) begin
      hold_left = pick_gap();
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Monitor: the result side is checked before a new request is predicted, since a
  // result can never leave at the same edge that its request is accepted.
  always @(posedge clk) begin
    queue_result_t  want;
    sched_request_t req;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected, tdata %0h", out_tdata));
        end else begin
          want = expected_results.pop_front();
          if (out_tdata[1:0] != want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      out_tdata[1:0], want.status));
          if (out_tdata[9:2] != want.proc_id)
            report_mismatch($sformatf("process id %0h, expected %0h",
                                      out_tdata[9:2], want.proc_id));
          if (out_tdata[17:10] != want.prio)
            report_mismatch($sformatf("priority %0h, expected %0h",
                                      out_tdata[17:10], want.prio));
        end
      end
      if (in_tvalid && in_tready) begin
        in_taken     = 1'b1;
        req.kind     = req_t'(in_tuser);
        req.proc_id  = in_tdata[7:0];
        req.prio     = in_tdata[15:8];
        expected_results.push_back(predict_queue_result(req));
      end
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic push_request(req_t kind, logic [ID_W-1:0] id, logic [PRIO_W-1:0] prio);
    sched_request_t req;
    req.kind    = kind;
    req.proc_id = id;
    req.prio    = prio;
    pending_requests.push_back(req);
  endtask

  // Random requests: removes carry random ignored fields; narrow priorities give many ties.
  task automatic push_random_requests(int count, int insert_pct, bit wide_prio);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < insert_pct)
        push_request(REQ_INSERT, ID_W'($urandom_range(0, 255)),
                     wide_prio ? PRIO_W'($urandom_range(0, 255))
                               : PRIO_W'($urandom_range(0, 7)));
      else
        push_request(REQ_REMOVE, ID_W'($urandom_range(0, 255)),
                     PRIO_W'($urandom_range(0, 255)));
    end
  endtask

  // Waits until every request went out and every result came back, then lets the
  // sequencer settle for longer than an insert takes.
  task automatic wait_idle();
    @(posedge clk);
    #1;
    while (pending_requests.size() != 0 || in_tvalid || expected_results.size() != 0) begin
      @(posedge clk);
      #1;
    end
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_mode(bit sorted);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= sorted;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    model_sorted = sorted;
  endtask

  initial begin
    int pct;
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      model_ids[k]   = '0;
      model_prios[k] = '0;
    end
    repeat (RESET_LEN) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Plain mode after reset: empty remove, extreme fields, tail order, empty again.
    push_request(REQ_REMOVE, 8'hFF, 8'hFF);
    push_request(REQ_INSERT, 8'h00, 8'h00);
    push_request(REQ_INSERT, 8'hFF, 8'hFF);
    push_request(REQ_INSERT, 8'hAA, 8'h55);
    push_request(REQ_INSERT, 8'h55, 8'hAA);
    repeat (4) push_request(REQ_REMOVE, 8'h00, 8'h00);
    push_request(REQ_REMOVE, 8'h00, 8'h00);
    wait_idle();

    // Priority mode: ordering, equal priorities first-come first-served, both extremes.
    write_mode(1'b1);
    push_request(REQ_INSERT, 8'd1, 8'd200);
    push_request(REQ_INSERT, 8'd2, 8'd100);
    push_request(REQ_INSERT, 8'd3, 8'd100);
    push_request(REQ_INSERT, 8'd4, 8'd0);
    push_request(REQ_INSERT, 8'd5, 8'd255);
    repeat (5) push_request(REQ_REMOVE, 8'hFF, 8'hFF);
    wait_idle();

    for (int ph = 0; ph < 12; ph++) begin
      write_mode((ph % 3 == 0) ? !model_sorted : 1'($urandom_range(0, 1)));
      case (ph % 4)
        0: begin
          pct = 90;
        end
        1: begin
          pct = 50;
        end
        2: begin
          pct = 30;
        end
        default: begin
          pct = 65;
        end
      endcase
      sender_gaps     = (ph % 4 != 3) && (ph != 5);
      receiver_stalls = (ph % 4 != 2);
      // One phase starts with a long receiver hold-off while requests keep coming.
      if (ph == 5) begin
        long_hold_req = 1'b1;
      end
      push_random_requests(75, pct, ph[0]);
      // Sender pauses until every outstanding result is back.
      wait_idle();
      push_random_requests(75, pct, !ph[0]);
      wait_idle();
    end

    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never came", expected_results.size()));
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/rqpf_pkg.sv
design/rqpf_cell.sv
design/rqpf_ctrl.sv
design/ready_queue_priority_or_fifo.sv
tb/tb_top.sv
